@@ rtl/txcw_pkg.sv @@
// ============================================================================
// txcw_pkg: shared types and constants for the text console writer
// Request codes, character codes, register indexes and the blank cell value.
// ============================================================================
package txcw_pkg;

  // Request codes carried on req_type
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_ATTR = 1'b0;
  localparam logic CFG_CTRL = 1'b1;

  // Character codes with special handling
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;

  // Tab stops fall on multiples of four cells
  localparam int unsigned TAB_STEP_W = 2;

  // White on black, no character
  localparam logic [15:0] BLANK_CELL = 16'h0F00;

  // Register reset values
  localparam logic [7:0] ATTR_RESET = 8'h0F;
  localparam logic       CTRL_RESET = 1'b1;

endpackage

@@ rtl/text_console_writer.sv @@
// ============================================================================
// text_console_writer: character writer for a text-mode screen
// Holds a COLUMNS x ROWS text memory of 16-bit cells and a cursor; handles
// put, clear and read requests, with scroll on overflow.
// ============================================================================
//
//  channel   direction  handshake            payload
//  --------  ---------  -------------------  ---------------------------------
//  request   in         req_valid/req_stall  req_type, char_code, cell_index
//  result    out        res_valid/res_stall  cursor_position, cell_value
//  config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Per request: a put of a plain character, newline or carriage return
//  moves the cursor; a tab writes one blank cell per step up to the next
//  tab stop; a read goes through the registered memory read port, skipped
//  for an index past the last cell; an unused request code only returns a
//  result; clear sweeps every cell. A put that runs past the last cell adds
//  a scroll, one memory port write per cell copied or blanked.
//  After reset, a clearing pass blanks the memory while req_stall stays
//  high; config writes are taken throughout.
//  One request is in flight at a time; a finished result waits in the output
//  register, and a stalled result beat holds the block in its final state.
//
module text_console_writer
  import txcw_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_index,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic [10:0] cursor_position,
  output logic [15:0] cell_value,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int unsigned CELLS  = COLUMNS * ROWS;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned COL_W  = $clog2(COLUMNS);

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW  = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ADDR_W:0]   CELLS_X   = (ADDR_W + 1)'(CELLS);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TAB    = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_BLANK  = 3'd4;
  localparam logic [2:0] S_CLEAR  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [2:0]        state;
  logic [ADDR_W-1:0] cursor;     // cell index of the cursor
  logic [COL_W-1:0]  col;        // cursor column, tracked beside the cursor
  logic [ADDR_W-1:0] ptr;        // sweep pointer for scroll, blank and clear
  logic              report;     // clear pass ends with a result beat
  logic              copy_pend;  // scroll read in flight, write it next cycle
  logic [ADDR_W-1:0] copy_dst;
  logic [15:0]       cell_pend;  // cell value of the request in progress
  logic [7:0]        text_attribute;
  logic              full_controls;
  logic [10:0]       res_cursor;
  logic [15:0]       res_cell;

  // Text memory: one write port, one registered read port
  logic [15:0]       mem [CELLS];
  logic [15:0]       rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [15:0]       wr_data;

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic              accept;
  logic              is_lf;
  logic              is_cr;
  logic              is_tab;
  logic              put_plain;
  logic [ADDR_W:0]   cursor_inc;
  logic [ADDR_W:0]   cursor_lf;
  logic [COL_W-1:0]  col_inc;
  logic              read_ok;
  logic              res_free;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign cfg_ready = 1'b1;

  assign is_lf     = (char_code == CH_LF);
  assign is_cr     = full_controls && (char_code == CH_CR);
  assign is_tab    = full_controls && (char_code == CH_TAB);
  assign put_plain = !is_lf && !is_cr && !is_tab;

  // Next cursor for a single step and for newline; one extra bit catches
  // the run past the last cell.
  assign cursor_inc = {1'b0, cursor} + 1'b1;
  assign cursor_lf  = {1'b0, cursor} + {1'b0, ROW_STEP} - (ADDR_W + 1)'(col);
  assign col_inc    = (col == LAST_COL) ? '0 : col + 1'b1;

  assign read_ok  = (32'(cell_index) < 32'(CELLS));
  assign res_free = !res_valid || !res_stall;

  // --------------------------------------------------------------------------
  // Memory port muxing. A pending scroll copy owns the write port; the
  // blank sweep waits for it.
  // --------------------------------------------------------------------------
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cursor;
    wr_data = BLANK_CELL;
    if (copy_pend) begin
      wr_en   = 1'b1;
      wr_addr = copy_dst;
      wr_data = rd_data;
    end else begin
      case (state)
        S_IDLE: begin
          wr_en   = accept && (req_type == REQ_PUT) && put_plain;
          wr_data = {text_attribute, char_code};
        end
        S_TAB: begin
          wr_en = 1'b1;
        end
        S_BLANK, S_CLEAR: begin
          wr_en   = 1'b1;
          wr_addr = ptr;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  assign rd_addr = (state == S_SCROLL) ? ptr : ADDR_W'(cell_index);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
      full_controls  <= CTRL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_ATTR) begin
        text_attribute <= cfg_data;
      end
      if (cfg_index == CFG_CTRL) begin
        full_controls <= cfg_data[0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      // Start with the clearing pass, silent
      state     <= S_CLEAR;
      ptr       <= '0;
      report    <= 1'b0;
      cursor    <= '0;
      col       <= '0;
      copy_pend <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // Every scroll read is written back one row up on the next cycle
      copy_pend <= (state == S_SCROLL);

      // Raise the result beat when one is loaded, drop it once taken
      if (state == S_DONE && res_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            cell_pend <= '0;
            case (req_type)
              REQ_PUT: begin
                if (is_tab) begin
                  state <= S_TAB;
                end else if (is_cr) begin
                  cursor <= cursor - ADDR_W'(col);
                  col    <= '0;
                  state  <= S_DONE;
                end else if (is_lf) begin
                  col <= '0;
                  if (cursor_lf >= CELLS_X) begin
                    cursor <= LAST_ROW;
                    ptr    <= ROW_STEP;
                    state  <= S_SCROLL;
                  end else begin
                    cursor <= cursor_lf[ADDR_W-1:0];
                    state  <= S_DONE;
                  end
                end else begin
                  // Character written by the memory port this cycle
                  if (cursor_inc >= CELLS_X) begin
                    cursor <= LAST_ROW;
                    col    <= '0;
                    ptr    <= ROW_STEP;
                    state  <= S_SCROLL;
                  end else begin
                    cursor <= cursor_inc[ADDR_W-1:0];
                    col    <= col_inc;
                    state  <= S_DONE;
                  end
                end
              end
              REQ_CLEAR: begin
                cursor <= '0;
                col    <= '0;
                ptr    <= '0;
                report <= 1'b1;
                state  <= S_CLEAR;
              end
              REQ_READ: begin
                // Read address issued now, data lands in S_READ
                state <= read_ok ? S_READ : S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end

        S_TAB: begin
          // Blank cell written this cycle; stop at a tab stop or the end
          if (cursor_inc >= CELLS_X) begin
            cursor <= LAST_ROW;
            col    <= '0;
            ptr    <= ROW_STEP;
            state  <= S_SCROLL;
          end else begin
            cursor <= cursor_inc[ADDR_W-1:0];
            col    <= col_inc;
            if (cursor_inc[TAB_STEP_W-1:0] == '0) begin
              state <= S_DONE;
            end
          end
        end

        S_READ: begin
          cell_pend <= rd_data;
          state     <= S_DONE;
        end

        S_SCROLL: begin
          // Read row r+1 cell, write it one row up on the next cycle
          copy_dst <= ptr - ROW_STEP;
          if (ptr == LAST_CELL) begin
            ptr   <= LAST_ROW;
            state <= S_BLANK;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end

        S_BLANK: begin
          // Hold while the last copy write uses the port
          if (!copy_pend) begin
            if (ptr == LAST_CELL) begin
              state <= S_DONE;
            end else begin
              ptr <= ptr + 1'b1;
            end
          end
        end

        S_CLEAR: begin
          if (ptr == LAST_CELL) begin
            state <= report ? S_DONE : S_IDLE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end

        S_DONE: begin
          // Load the result beat once the output register is free
          if (res_free) begin
            res_cursor <= 11'(cursor);
            res_cell   <= cell_pend;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cursor_position = res_cursor;
  assign cell_value      = res_cell;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (32'(cursor) < 32'(CELLS)) && (32'(col) < 32'(COLUMNS)))
    else $error("cursor or column out of range");

  a_copy_from_scroll: assert property (@(posedge clk) disable iff (rst)
    copy_pend |-> ($past(state) == S_SCROLL))
    else $error("scroll copy write without a scroll read");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCROLL || state == S_BLANK) |-> (cursor == LAST_ROW && col == '0))
    else $error("cursor not at last row start during scroll");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted request did not start work");

endmodule
